/* rtl/core/bdq_pkg.sv */
// Shared constants, types and helpers for the byte deque with search.
package bdq_pkg;

  // Storage geometry.
  localparam int DEPTH = 64;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = PTR_W + 1;

  // Field widths of the channels.
  localparam int MODE_W     = 3;
  localparam int VALUE_W    = 8;
  localparam int STATUS_W   = 2;
  localparam int POSITION_W = 6;
  localparam int COUNT_W    = 7;

  // Operation codes carried on the mode field.
  localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SEARCH     = 3'd4;

  // Status codes reported with every result.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_HOLD
  } state_t;

  // One write into the entry store.
  typedef struct packed {
    logic               en;
    logic [PTR_W-1:0]   addr;
    logic [VALUE_W-1:0] data;
  } wr_req_t;

  // One result beat.
  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic                  found;
    logic [POSITION_W-1:0] position;
    logic [COUNT_W-1:0]    count;
  } result_t;

  // Fold a sum below 2*DEPTH back into the ring.
  function automatic logic [PTR_W-1:0] wrap_index(input logic [SUM_W-1:0] s);
    logic [SUM_W-1:0] folded;
    folded = (s >= SUM_W'(DEPTH)) ? (s - SUM_W'(DEPTH)) : s;
    return folded[PTR_W-1:0];
  endfunction

endpackage

/* rtl/core/bdq_store.sv */
// Entry store of the deque: one write port and one registered read port.
module bdq_store
  import bdq_pkg::*;
(
  input  logic               clk,
  input  wr_req_t            wr_req,
  input  logic [PTR_W-1:0]   rd_addr,
  output logic [VALUE_W-1:0] rd_data
);

  logic [VALUE_W-1:0] mem [DEPTH];
  logic [VALUE_W-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_req.en) begin
      mem[wr_req.addr] <= wr_req.data;
    end
  end

  // Read port, data registered.
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/core/byte_deque_with_search_top.sv */
// Top level of the byte deque with a front-to-back linear search.
//
//   channel | ports                                    | direction
//   --------+------------------------------------------+----------
//   input   | in_valid, in_ready, in_mode, in_value    | in
//   result  | out_valid, out_ready, out_status,        | out
//           | out_found, out_position, out_count       |
//
// Pushes and pops finish in the cycle of their input beat.
// A search walks from the front and ends at the first match or after the last
// entry; the walk reads the store one entry per cycle.
// Synchronous active-low reset empties the deque; the store is not cleared.
// A finished result waits in the output register; if that is still full,
// a second result parks internally and input is held off until it drains.
module byte_deque_with_search_top
  import bdq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [MODE_W-1:0]     in_mode,
  input  logic [VALUE_W-1:0]    in_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [STATUS_W-1:0]   out_status,
  output logic                  out_found,
  output logic [POSITION_W-1:0] out_position,
  output logic [COUNT_W-1:0]    out_count
);

  state_t             state_r, state_nxt;
  logic [PTR_W-1:0]   front_r, front_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [VALUE_W-1:0] key_r, key_nxt;
  logic [CNT_W-1:0]   issue_idx_r, issue_idx_nxt;
  logic               cmp_vld_r, cmp_vld_nxt;
  logic [PTR_W-1:0]   cmp_idx_r, cmp_idx_nxt;
  logic               out_valid_r, out_valid_nxt;
  result_t            out_res_r, out_res_nxt;
  result_t            pend_r, pend_nxt;

  wr_req_t            wr_req;
  logic [PTR_W-1:0]   rd_addr;
  logic [VALUE_W-1:0] rd_data;

  logic               in_beat;
  logic               out_free;
  logic               res_vld;
  result_t            res;
  logic               issue;
  logic [PTR_W-1:0]   front_dec;

  bdq_store u_store (
    .clk     (clk),
    .wr_req  (wr_req),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign in_beat   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign issue     = (state_r == S_SEARCH) && (issue_idx_r < count_r);
  assign front_dec = (front_r == '0) ? PTR_W'(DEPTH - 1) : (front_r - 1'b1);
  assign rd_addr   = wrap_index(SUM_W'(front_r) + SUM_W'(issue_idx_r));

  // Sequencer: operations, search walk and result routing.
  always_comb begin
    state_nxt     = state_r;
    front_nxt     = front_r;
    count_nxt     = count_r;
    key_nxt       = key_r;
    issue_idx_nxt = issue_idx_r;
    cmp_vld_nxt   = 1'b0;
    cmp_idx_nxt   = cmp_idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_res_nxt   = out_res_r;
    pend_nxt      = pend_r;
    wr_req        = '{en: 1'b0, addr: front_r, data: in_value};
    res_vld       = 1'b0;
    res           = '{status: ST_OK, found: 1'b0, position: '0,
                      count: COUNT_W'(count_r)};

    case (state_r)
      S_IDLE: begin
        if (in_beat) begin
          case (in_mode)
            MODE_PUSH_FRONT: begin
              res_vld = 1'b1;
              if (count_r >= CNT_W'(DEPTH)) begin
                res.status = ST_FULL;
              end else begin
                front_nxt   = front_dec;
                wr_req.en   = 1'b1;
                wr_req.addr = front_dec;
                count_nxt   = count_r + 1'b1;
              end
            end
            MODE_PUSH_BACK: begin
              res_vld = 1'b1;
              if (count_r >= CNT_W'(DEPTH)) begin
                res.status = ST_FULL;
              end else begin
                wr_req.en   = 1'b1;
                wr_req.addr = wrap_index(SUM_W'(front_r) + SUM_W'(count_r));
                count_nxt   = count_r + 1'b1;
              end
            end
            MODE_POP_FRONT: begin
              res_vld = 1'b1;
              if (count_r == '0) begin
                res.status = ST_EMPTY;
              end else begin
                front_nxt = wrap_index(SUM_W'(front_r) + SUM_W'(1));
                count_nxt = count_r - 1'b1;
              end
            end
            MODE_POP_BACK: begin
              res_vld = 1'b1;
              if (count_r == '0) begin
                res.status = ST_EMPTY;
              end else begin
                count_nxt = count_r - 1'b1;
              end
            end
            MODE_SEARCH: begin
              if (count_r == '0) begin
                res_vld    = 1'b1;
                res.status = ST_EMPTY;
              end else begin
                key_nxt       = in_value;
                issue_idx_nxt = '0;
                state_nxt     = S_SEARCH;
              end
            end
            default: begin
              res_vld = 1'b1;
            end
          endcase
          res.count = COUNT_W'(count_nxt);
        end
      end
      S_SEARCH: begin
        // Issue one read per cycle; compare the entry read last cycle.
        if (issue) begin
          issue_idx_nxt = issue_idx_r + 1'b1;
          cmp_idx_nxt   = issue_idx_r[PTR_W-1:0];
        end
        if (cmp_vld_r && (rd_data == key_r)) begin
          res_vld      = 1'b1;
          res.found    = 1'b1;
          res.position = POSITION_W'(cmp_idx_r);
        end else if (cmp_vld_r && ((CNT_W'(cmp_idx_r) + 1'b1) == count_r)) begin
          res_vld = 1'b1;
        end else begin
          cmp_vld_nxt = issue;
        end
        if (res_vld) begin
          state_nxt = S_IDLE;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = pend_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Route a new result to the output register or park it.
    if (res_vld) begin
      if (out_free) begin
        out_valid_nxt = 1'b1;
        out_res_nxt   = res;
      end else begin
        pend_nxt  = res;
        state_nxt = S_HOLD;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and walk registers.
  always_ff @(posedge clk) begin
    key_r       <= key_nxt;
    issue_idx_r <= issue_idx_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    out_res_r   <= out_res_nxt;
    pend_r      <= pend_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_res_r.status;
  assign out_found    = out_res_r.found;
  assign out_position = out_res_r.position;
  assign out_count    = out_res_r.count;

  // The entry count never exceeds the store depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  // The front pointer stays inside the ring.
  a_front_bound: assert property (@(posedge clk) disable iff (!rst_n)
    SUM_W'(front_r) < SUM_W'(DEPTH))
    else $error("front pointer out of range");

  // An accepted beat leaves either a result or a busy sequencer.
  a_beat_progress: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> (out_valid_r || (state_r != S_IDLE)))
    else $error("accepted beat produced nothing");

  // A compare only ever looks at a stored entry.
  a_cmp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_vld_r |-> ((state_r == S_SEARCH) && (CNT_W'(cmp_idx_r) < count_r)))
    else $error("compare outside stored entries");

  // The store is not written during a search walk.
  a_no_write_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEARCH) |-> !wr_req.en)
    else $error("store write during search");

endmodule
